@@ hdl/sample_dma_buffer_cache_assert.svh @@
// assertion macros used by the checker file
`ifndef SAMPLE_DMA_BUFFER_CACHE_ASSERT_SVH
`define SAMPLE_DMA_BUFFER_CACHE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SDBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SDBC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sdbc_pkg.sv @@
// ---------------------------------------------------------------------------
// sdbc_pkg
// Shared types and constants of the sample buffer cache: field widths,
// action and status codes, and the controller/datapath command structs.
// ---------------------------------------------------------------------------
package sdbc_pkg;

  // payload field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned DONE_W    = 5;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned OFF_W     = 12;
  localparam int unsigned SLOT_W    = 4;

  // request kinds
  localparam logic ACT_REQ  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // clears bit 0 of a transfer source address
  localparam logic [ADDR_W-1:0] EVEN_MASK = 32'hFFFF_FFFE;

  // result status codes
  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_RELOAD   = 2'd1,
    ST_FALLBACK = 2'd2
  } sdbc_status_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // take the input beat into the request registers
    logic rd_en;    // read the entry table at rd_idx
    logic eval;     // compare the entry read last cycle
    logic age_wr;   // write back the aged entry read last cycle
    logic resolve;  // settle a miss: reload or fallback
    logic push;     // move the result into the output register
  } sdbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;       // evaluated entry holds the request range
    logic out_free;  // output register can take a result
  } sdbc_sts_t;

endpackage

@@ hdl/sdbc_in_if.sv @@
// ---------------------------------------------------------------------------
// sdbc_in_if
// Request channel: valid/ready handshake carrying one request or tick.
// ---------------------------------------------------------------------------
interface sdbc_in_if import sdbc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;
  logic [DONE_W-1:0] completed_count;

  modport source (
    output valid, action, address, length, completed_count,
    input  ready
  );

  modport sink (
    input  valid, action, address, length, completed_count,
    output ready
  );

endinterface

@@ hdl/sdbc_out_if.sv @@
// ---------------------------------------------------------------------------
// sdbc_out_if
// Result channel: valid/ready handshake carrying one lookup result.
// ---------------------------------------------------------------------------
interface sdbc_out_if import sdbc_pkg::*; ();

  logic                 valid;
  logic                 ready;
  sdbc_status_e         status;
  logic [IDX_OUT_W-1:0] entry_index;
  logic [OFF_W-1:0]     byte_offset;
  logic [ADDR_W-1:0]    transfer_source;
  logic [SLOT_W-1:0]    transfer_slot;

  modport source (
    output valid, status, entry_index, byte_offset, transfer_source, transfer_slot,
    input  ready
  );

  modport sink (
    input  valid, status, entry_index, byte_offset, transfer_source, transfer_slot,
    output ready
  );

endinterface

@@ hdl/sdbc_ctrl.sv @@
// ---------------------------------------------------------------------------
// sdbc_ctrl
// Sequencer of the buffer cache: accepts one beat at a time, walks the entry
// table one entry per cycle for a lookup or an aging sweep, and hands the
// result to the output register.
// ---------------------------------------------------------------------------
module sdbc_ctrl import sdbc_pkg::*; #(
  parameter  int unsigned ENTRIES = 16,
  localparam int unsigned IdxW    = $clog2(ENTRIES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_action_i,
  output logic            in_ready_o,
  input  sdbc_sts_t       sts_i,
  output sdbc_cmd_t       cmd_o,
  output logic [IdxW-1:0] rd_idx_o,
  output logic [IdxW-1:0] ev_idx_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_FINISH,
    S_AGE
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;      // next entry to read
  logic            lag_q;      // a read issued last cycle is being looked at
  logic [IdxW-1:0] lag_idx_q;  // entry of that read
  logic            issued_q;   // every entry has been read

  // state and walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      lag_q     <= 1'b0;
      lag_idx_q <= '0;
      issued_q  <= 1'b0;
    end else begin
      unique case (state_q) inside
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q    <= '0;
            lag_q    <= 1'b0;
            issued_q <= 1'b0;
            state_q  <= (in_action_i == ACT_TICK) ? S_AGE : S_SCAN;
          end
        end
        S_SCAN, S_AGE: begin
          // read one entry per cycle, look at it the cycle after
          if (!issued_q) begin
            lag_q     <= 1'b1;
            lag_idx_q <= idx_q;
            if (idx_q == LastIdx) begin
              issued_q <= 1'b1;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else begin
            lag_q <= 1'b0;
          end
          if (state_q == S_SCAN) begin
            if (lag_q && sts_i.hit) begin
              state_q <= S_FINISH;
            end else if (lag_q && (lag_idx_q == LastIdx)) begin
              state_q <= S_RESOLVE;
            end
          end else if (lag_q && (lag_idx_q == LastIdx)) begin
            state_q <= S_IDLE;
          end
        end
        S_RESOLVE: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd_en   = ((state_q == S_SCAN) || (state_q == S_AGE)) && !issued_q;
    cmd_o.eval    = (state_q == S_SCAN) && lag_q;
    cmd_o.age_wr  = (state_q == S_AGE) && lag_q;
    cmd_o.resolve = (state_q == S_RESOLVE);
    cmd_o.push    = (state_q == S_FINISH) && sts_i.out_free;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign rd_idx_o   = idx_q;
  assign ev_idx_o   = lag_idx_q;

endmodule

@@ hdl/sdbc_dp.sv @@
// ---------------------------------------------------------------------------
// sdbc_dp
// Datapath of the buffer cache: entry table memory with per-entry valid
// bits, window compare, oldest-entry tracking, transfer counters and the
// output register.
// ---------------------------------------------------------------------------
module sdbc_dp import sdbc_pkg::*; #(
  parameter  int unsigned ENTRIES      = 16,
  parameter  int unsigned BUFFER_BYTES = 2048,
  parameter  int unsigned AGE_BITS     = 16,
  localparam int unsigned IdxW         = $clog2(ENTRIES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdbc_cmd_t            cmd_i,
  input  logic [IdxW-1:0]      rd_idx_i,
  input  logic [IdxW-1:0]      ev_idx_i,
  input  logic                 in_action_i,
  input  logic [ADDR_W-1:0]    in_address_i,
  input  logic [LEN_W-1:0]     in_length_i,
  input  logic [DONE_W-1:0]    in_completed_i,
  output sdbc_sts_t            sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output sdbc_status_e         out_status_o,
  output logic [IDX_OUT_W-1:0] out_index_o,
  output logic [OFF_W-1:0]     out_offset_o,
  output logic [ADDR_W-1:0]    out_source_o,
  output logic [SLOT_W-1:0]    out_slot_o
);

  localparam int unsigned RowW = ADDR_W + AGE_BITS;
  localparam int unsigned OutW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (OutW > DONE_W) ? OutW : DONE_W;
  localparam logic [AGE_BITS-1:0] AgeOne  = AGE_BITS'(1);
  localparam logic [AGE_BITS-1:0] AgeZero = '0;
  localparam logic [IdxW-1:0]     LastIdx = IdxW'(ENTRIES - 1);

  // entry table: {start, age} per row; an entry never written reads as reset
  logic [RowW-1:0]     mem_q [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;
  logic [RowW-1:0]     rd_row_q;
  logic                rd_vld_q;

  logic [ADDR_W-1:0]   req_addr_q;
  logic [ADDR_W-1:0]   req_end_q;
  logic [IdxW-1:0]     best_idx_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic [OutW-1:0]     outst_q;
  logic [IdxW-1:0]     slot_q;

  sdbc_status_e        res_status_q;
  logic [IdxW-1:0]     res_idx_q;
  logic [OFF_W-1:0]    res_off_q;
  logic [ADDR_W-1:0]   res_src_q;
  logic [IdxW-1:0]     res_slot_q;

  logic                out_valid_q;
  sdbc_status_e        out_status_q;
  logic [IDX_OUT_W-1:0] out_index_q;
  logic [OFF_W-1:0]    out_offset_q;
  logic [ADDR_W-1:0]   out_source_q;
  logic [SLOT_W-1:0]   out_slot_q;

  logic [ADDR_W-1:0]   start_eff;
  logic [AGE_BITS-1:0] age_eff;
  logic [AGE_BITS-1:0] age_inc;
  logic [ADDR_W-1:0]   win_end;
  logic [ADDR_W-1:0]   hit_off;
  logic [ADDR_W-1:0]   src;
  logic                hit;
  logic                reload;
  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  logic [RowW-1:0]     wr_row;
  logic [CmpW-1:0]     done_ext;
  logic [CmpW-1:0]     outst_ext;
  logic                out_free;

  // entry read last cycle, reset value where never written
  assign start_eff = rd_vld_q ? rd_row_q[RowW-1:AGE_BITS] : '0;
  assign age_eff   = rd_vld_q ? rd_row_q[AGE_BITS-1:0] : AgeOne;
  assign age_inc   = (&age_eff) ? age_eff : age_eff + 1'b1;

  // window compare, ends taken modulo 2^32
  assign win_end = start_eff + ADDR_W'(BUFFER_BYTES);
  assign hit     = (start_eff <= req_addr_q) && (req_end_q <= win_end);
  assign hit_off = req_addr_q - start_eff;

  // miss handling
  assign reload = (best_age_q != AgeZero) && (outst_q < OutW'(ENTRIES));
  assign src    = req_addr_q & EVEN_MASK;

  // table write port
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = ev_idx_i;
    wr_row = {start_eff, age_inc};
    if (cmd_i.eval && hit) begin
      wr_en  = 1'b1;
      wr_row = {start_eff, AgeZero};
    end else if (cmd_i.age_wr) begin
      wr_en  = 1'b1;
    end else if (cmd_i.resolve && reload) begin
      wr_en  = 1'b1;
      wr_idx = best_idx_q;
      wr_row = {src, AgeZero};
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_row;
    end
    if (cmd_i.rd_en) begin
      rd_row_q <= mem_q[rd_idx_i];
    end
  end

  // valid bits and registered valid of the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= valid_q[rd_idx_i];
      end
    end
  end

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_addr_q <= in_address_i;
      req_end_q  <= in_address_i + ADDR_W'(in_length_i);
    end
  end

  assign done_ext  = CmpW'(in_completed_i);
  assign outst_ext = CmpW'(outst_q);

  // oldest tracking, outstanding count and descriptor slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_q <= '0;
      best_age_q <= '0;
      outst_q    <= '0;
      slot_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        best_idx_q <= '0;
        best_age_q <= '0;
        if (in_action_i == ACT_TICK) begin
          outst_q <= (done_ext >= outst_ext) ? '0 : OutW'(outst_ext - done_ext);
        end
      end
      if (cmd_i.eval && (age_eff > best_age_q)) begin
        best_idx_q <= ev_idx_i;
        best_age_q <= age_eff;
      end
      if (cmd_i.resolve && reload) begin
        outst_q <= outst_q + 1'b1;
        slot_q  <= (slot_q == LastIdx) ? '0 : slot_q + 1'b1;
      end
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && hit) begin
      res_status_q <= ST_HIT;
      res_idx_q    <= ev_idx_i;
      res_off_q    <= hit_off[OFF_W-1:0];
      res_src_q    <= '0;
      res_slot_q   <= '0;
    end else if (cmd_i.resolve) begin
      res_idx_q <= best_idx_q;
      if (reload) begin
        res_status_q <= ST_RELOAD;
        res_off_q    <= {{(OFF_W-1){1'b0}}, req_addr_q[0]};
        res_src_q    <= src;
        res_slot_q   <= slot_q;
      end else begin
        res_status_q <= ST_FALLBACK;
        res_off_q    <= '0;
        res_src_q    <= '0;
        res_slot_q   <= '0;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_index_q  <= IDX_OUT_W'(res_idx_q);
      out_offset_q <= res_off_q;
      out_source_q <= res_src_q;
      out_slot_q   <= SLOT_W'(res_slot_q);
    end
  end

  assign sts_o.hit      = hit;
  assign sts_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_index_o  = out_index_q;
  assign out_offset_o = out_offset_q;
  assign out_source_o = out_source_q;
  assign out_slot_o   = out_slot_q;

endmodule

@@ hdl/sample_dma_buffer_cache.sv @@
// ---------------------------------------------------------------------------
// sample_dma_buffer_cache
// Cache of sample buffers with oldest-entry replacement and transfer issue.
// ---------------------------------------------------------------------------
// in_i carries one beat per request (action 0) or frame tick (action 1).
// A request returns exactly one beat on out_o: hit, reload with a transfer
// descriptor, or fallback. A tick retires completed transfers, ages every
// entry and returns nothing.
// The entry table is a single-port-write memory walked one entry per cycle,
// so ENTRIES sets the timing: a request walks the table (an early hit ends
// the walk sooner), settles a miss and then moves its result into the
// output register; a tick walks the whole table. One beat is in work at a
// time; in_i.ready is high whenever the sequencer is idle, also while a
// finished result still waits on out_o.
// Reset empties the output register and marks every entry unwritten, so the
// table reads as start 0, age 1 at once with no clearing pass.
// When the receiver stalls, the result holds on out_o; a following result
// waits in the datapath until the output register frees.
// ---------------------------------------------------------------------------
module sample_dma_buffer_cache import sdbc_pkg::*; #(
  parameter int unsigned ENTRIES      = 16,
  parameter int unsigned BUFFER_BYTES = 2048,
  parameter int unsigned AGE_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdbc_in_if.sink    in_i,
  sdbc_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  sdbc_cmd_t       cmd;
  sdbc_sts_t       sts;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] ev_idx;

  // sequencer
  sdbc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx),
    .ev_idx_o    (ev_idx)
  );

  // table, compare and output
  sdbc_dp #(
    .ENTRIES      (ENTRIES),
    .BUFFER_BYTES (BUFFER_BYTES),
    .AGE_BITS     (AGE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_idx_i       (rd_idx),
    .ev_idx_i       (ev_idx),
    .in_action_i    (in_i.action),
    .in_address_i   (in_i.address),
    .in_length_i    (in_i.length),
    .in_completed_i (in_i.completed_count),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_status_o   (out_o.status),
    .out_index_o    (out_o.entry_index),
    .out_offset_o   (out_o.byte_offset),
    .out_source_o   (out_o.transfer_source),
    .out_slot_o     (out_o.transfer_slot)
  );

endmodule

@@ hdl/sdbc_checker.sv @@
// ---------------------------------------------------------------------------
// sdbc_checker
// Port-level checks of the buffer cache, bound to the top level.
// ---------------------------------------------------------------------------
`include "sample_dma_buffer_cache_assert.svh"

module sdbc_checker import sdbc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input sdbc_status_e      out_status_i,
  input logic [OFF_W-1:0]  out_offset_i,
  input logic [ADDR_W-1:0] out_source_i,
  input logic [SLOT_W-1:0] out_slot_i
);

  // stalled result beat holds
  `SDBC_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_source_i), "result changed while stalled")

  // one beat in work: the cycle after an accept takes nothing
  `SDBC_ASSERT_NXT(a_one_in_work, in_valid_i && in_ready_i, !in_ready_i, "input taken while busy")

  // no result appears the cycle after an accept
  `SDBC_ASSERT_NXT(a_no_instant, in_valid_i && in_ready_i && !out_valid_i, !out_valid_i, "result too early")

  // only a reload carries a transfer descriptor
  `SDBC_ASSERT_NOW(a_no_xfer, out_valid_i && (out_status_i != ST_RELOAD), (out_source_i == '0) && (out_slot_i == '0), "descriptor on non-reload")

  // a reload source is even and its offset is at most one
  `SDBC_ASSERT_NOW(a_reload_even, out_valid_i && (out_status_i == ST_RELOAD), (out_source_i[0] == 1'b0) && (out_offset_i[OFF_W-1:1] == '0), "bad reload source")

endmodule

bind sample_dma_buffer_cache sdbc_checker u_sdbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_offset_i (out_o.byte_offset),
  .out_source_i (out_o.transfer_source),
  .out_slot_i   (out_o.transfer_slot)
);

@@ test/tb_sample_dma_buffer_cache.sv @@
// ---------------------------------------------------------------------------
// tb_sample_dma_buffer_cache
// Self-checking bench for the sample buffer cache. A shadow copy of the entry
// table predicts every request result: hit, reload with transfer or fallback.
// Results are compared field by field, oldest first. Directed beats cover the
// field extremes and corner cases, then about 1300 random beats follow.
// Random idling runs on both channels, and one long receiver hold-off fills
// the block.
// ---------------------------------------------------------------------------
module tb_sample_dma_buffer_cache;
  import sdbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES        = 16;
  localparam int unsigned BUFFER_BYTES   = 2048;
  localparam int unsigned AGE_BITS       = 16;
  localparam int unsigned RANDOM_BEATS   = 1325;
  localparam int unsigned SQUEEZE_AFTER  = 600;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES   = 2 * (ENTRIES + 4) + 10;
  localparam int unsigned HOT_POOL_MAX   = 24;
  localparam logic [AGE_BITS-1:0] AGE_SAT = {AGE_BITS{1'b1}};

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [DONE_W-1:0] completed_count;
  } cache_beat_t;

  typedef struct packed {
    sdbc_status_e         status;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [OFF_W-1:0]     byte_offset;
    logic [ADDR_W-1:0]    transfer_source;
    logic [SLOT_W-1:0]    transfer_slot;
  } lookup_result_t;

  logic clk_i;
  logic rst_ni;

  sdbc_in_if  in_if ();
  sdbc_out_if out_if ();

  sample_dma_buffer_cache #(
    .ENTRIES     (ENTRIES),
    .BUFFER_BYTES(BUFFER_BYTES),
    .AGE_BITS    (AGE_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // stimulus and expectations
  cache_beat_t    pending_beats[$];
  lookup_result_t lookup_results_due[$];
  logic [ADDR_W-1:0] hot_bases[$];

  // shadow copy of the cache state
  logic [ADDR_W-1:0]   ent_start[ENTRIES];
  logic [AGE_BITS-1:0] ent_age[ENTRIES];
  int unsigned         busy_transfers;
  logic [SLOT_W-1:0]   next_slot;

  // run statistics
  int unsigned failures;
  int unsigned hit_count;
  int unsigned reload_count;
  int unsigned fallback_count;
  int unsigned tick_count;

  // driver and receiver state
  cache_beat_t send_beat;
  int unsigned send_pause;
  int unsigned send_mode;
  int unsigned beats_sent;
  int unsigned recv_stall;
  int unsigned recv_mode;
  int unsigned recv_cycles;
  int unsigned results_taken;
  logic        recv_ready_nxt;
  bit          squeeze_done;
  logic        squeeze_on;
  int unsigned quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // random pause length; mode 0 never idles
  function automatic int unsigned pick_pause(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
    end
    if (r < 30) return 0;
    if (r < 90) return $urandom_range(1, 6);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_request(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    cache_beat_t b;
    b.action          = ACT_REQ;
    b.address         = addr;
    b.length          = len;
    b.completed_count = '0;
    pending_beats.push_back(b);
  endtask

  task automatic push_tick(input logic [DONE_W-1:0] done);
    cache_beat_t b;
    b.action          = ACT_TICK;
    b.address         = $urandom;
    b.length          = LEN_W'($urandom_range(0, 65535));
    b.completed_count = done;
    pending_beats.push_back(b);
  endtask

  // shadow cache: apply one accepted beat, queue the result it causes
  task automatic apply_cache_beat(input cache_beat_t b);
    logic [ADDR_W-1:0]   req_end;
    logic [ADDR_W-1:0]   win_end;
    logic [ADDR_W-1:0]   diff;
    int unsigned         victim;
    logic [AGE_BITS-1:0] victim_age;
    bit                  found;
    lookup_result_t      res;
    if (b.action == ACT_TICK) begin
      tick_count++;
      if (b.completed_count >= busy_transfers) busy_transfers = 0;
      else busy_transfers -= b.completed_count;
      for (int i = 0; i < ENTRIES; i++)
        if (ent_age[i] != AGE_SAT) ent_age[i] = ent_age[i] + 1'b1;
      return;
    end
    req_end    = b.address + ADDR_W'(b.length);
    victim     = 0;
    victim_age = '0;
    found      = 1'b0;
    res        = '0;
    // scan in order: remember first oldest, stop on first covering window
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found) begin
        win_end = ent_start[i] + ADDR_W'(BUFFER_BYTES);
        if (ent_age[i] > victim_age) begin
          victim     = i;
          victim_age = ent_age[i];
        end
        if (ent_start[i] <= b.address && req_end <= win_end) begin
          found             = 1'b1;
          ent_age[i]        = '0;
          diff              = b.address - ent_start[i];
          res.status        = ST_HIT;
          res.entry_index   = IDX_OUT_W'(i);
          res.byte_offset   = diff[OFF_W-1:0];
        end
      end
    end
    if (found) begin
      hit_count++;
    end else if (victim_age == 0 || busy_transfers >= ENTRIES) begin
      // no aged entry or no free transfer: hand back the candidate as is
      fallback_count++;
      res.status      = ST_FALLBACK;
      res.entry_index = IDX_OUT_W'(victim);
    end else begin
      reload_count++;
      res.status          = ST_RELOAD;
      res.entry_index     = IDX_OUT_W'(victim);
      res.byte_offset     = OFF_W'(b.address[0]);
      res.transfer_source = b.address & EVEN_MASK;
      res.transfer_slot   = next_slot;
      ent_start[victim]   = b.address & EVEN_MASK;
      ent_age[victim]     = '0;
      next_slot           = SLOT_W'((int'(next_slot) + 1) % ENTRIES);
      busy_transfers++;
    end
    lookup_results_due.push_back(res);
  endtask

  // driver: next beat from the pending queue, random pauses between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid           <= 1'b0;
      in_if.action          <= ACT_REQ;
      in_if.address         <= '0;
      in_if.length          <= '0;
      in_if.completed_count <= '0;
      send_pause            = 0;
      send_mode             = 1;
      beats_sent            = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_pause > 0 && !squeeze_on) begin
        send_pause--;
        in_if.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        send_beat             = pending_beats.pop_front();
        in_if.valid           <= 1'b1;
        in_if.action          <= send_beat.action;
        in_if.address         <= send_beat.address;
        in_if.length          <= send_beat.length;
        in_if.completed_count <= send_beat.completed_count;
        beats_sent++;
        if (beats_sent % 150 == 0) send_mode = $urandom_range(0, 2);
        send_pause = pick_pause(send_mode);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off that fills the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready  <= 1'b0;
      squeeze_on    <= 1'b0;
      recv_stall    = 0;
      recv_mode     = 0;
      recv_cycles   = 0;
      results_taken = 0;
      squeeze_done  = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) results_taken++;
      recv_cycles++;
      if (recv_cycles % 256 == 0) recv_mode = $urandom_range(0, 2);
      if (!squeeze_done && results_taken >= SQUEEZE_AFTER) begin
        squeeze_done = 1'b1;
        recv_stall   = SQUEEZE_CYCLES;
        squeeze_on   <= 1'b1;
      end else if (recv_stall == 0) begin
        squeeze_on <= 1'b0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        recv_ready_nxt = 1'b0;
      end else begin
        recv_stall     = pick_pause(recv_mode);
        recv_ready_nxt = (recv_stall == 0);
      end
      out_if.ready <= recv_ready_nxt;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        apply_cache_beat({in_if.action, in_if.address, in_if.length, in_if.completed_count});
      if (out_if.valid && out_if.ready) begin
        if (lookup_results_due.size() == 0) begin
          $error("result beat with no request pending");
          failures++;
        end else begin
          lookup_result_t exp_res;
          exp_res = lookup_results_due.pop_front();
          if (out_if.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_if.status);
            failures++;
          end
          if (out_if.entry_index !== exp_res.entry_index) begin
            $error("entry_index: expected %0d, got %0d", exp_res.entry_index,
                   out_if.entry_index);
            failures++;
          end
          if (out_if.byte_offset !== exp_res.byte_offset) begin
            $error("byte_offset: expected 0x%0h, got 0x%0h", exp_res.byte_offset,
                   out_if.byte_offset);
            failures++;
          end
          if (out_if.transfer_source !== exp_res.transfer_source) begin
            $error("transfer_source: expected 0x%08h, got 0x%08h", exp_res.transfer_source,
                   out_if.transfer_source);
            failures++;
          end
          if (out_if.transfer_slot !== exp_res.transfer_slot) begin
            $error("transfer_slot: expected %0d, got %0d", exp_res.transfer_slot,
                   out_if.transfer_slot);
            failures++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned tick_pct;
    int unsigned r;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    rst_ni                = 1'b0;
    failures              = 0;
    hit_count             = 0;
    reload_count          = 0;
    fallback_count        = 0;
    tick_count            = 0;
    busy_transfers        = 0;
    next_slot             = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      ent_start[i] = '0;
      ent_age[i]   = AGE_BITS'(1);
    end

    // directed: reset table hits, length zero at window end, wrapped ranges
    push_request(32'h0000_0000, 16'h0000);
    push_request(32'h0000_0800, 16'h0000);
    push_request(32'hFFFF_FFF0, 16'h0020);
    push_request(32'hFFFF_FFFF, 16'hFFFF);
    push_request(32'hFFFF_FF11, 16'h0100);
    // reload the remaining entries until every age is zero
    for (int k = 2; k < ENTRIES; k++)
      push_request(32'h1000_0001 + ADDR_W'((k - 2) << 16), LEN_W'(k * 100));
    // all ages zero gives the first entry as fallback
    push_request(32'h5555_5555, 16'hAAAA);
    push_tick(5'd0);
    // one more reload fills the transfer ring, the next miss falls back
    push_request(32'hAAAA_AAAA, 16'h5555);
    push_request(32'h2000_0000, 16'h0010);
    push_tick(5'd16);
    // more completions than outstanding transfers
    push_tick(5'd15);
    push_request(32'h1000_0001, 16'h07FF);

    // random: mostly requests around recently used bases, some noise
    tick_pct = 15;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        r = $urandom_range(0, 2);
        tick_pct = (r == 0) ? 5 : (r == 1) ? 15 : 35;
      end
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        if ($urandom_range(0, 9) == 0) push_tick(DONE_W'($urandom_range(0, 16)));
        else push_tick(DONE_W'($urandom_range(0, 3)));
      end else if (r < tick_pct + 5) begin
        push_request($urandom, LEN_W'($urandom_range(0, 65535)));
      end else begin
        if (hot_bases.size() == 0 || $urandom_range(0, 3) == 0) begin
          r = $urandom_range(0, 9);
          if (r < 6) base = $urandom;
          else if (r < 8) base = 32'hFFFF_F000 + $urandom_range(0, 4095);
          else base = $urandom_range(0, 8191);
          hot_bases.push_back(base);
          if (hot_bases.size() > HOT_POOL_MAX) void'(hot_bases.pop_front());
        end
        base = hot_bases[$urandom_range(0, hot_bases.size() - 1)];
        addr = base + $urandom_range(0, 2100);
        if ($urandom_range(0, 3) == 0) len = LEN_W'($urandom_range(0, 2100));
        else len = LEN_W'($urandom_range(0, 256));
        push_request(addr, len);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the last beat to go in and every result to come back
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_if.valid || lookup_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d requests: %0d hits, %0d reloads, %0d fallbacks",
             hit_count + reload_count + fallback_count, hit_count, reload_count,
             fallback_count);
    $display("plus %0d frame ticks, %0d mismatches", tick_count, failures);
    if (failures == 0 && lookup_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
